// ----- sv/gcd_pkg.sv -----
package gcd_pkg;

    localparam int MAX_UNITS = 8;
    localparam int CNT_W     = $clog2(MAX_UNITS + 1);
    localparam int IDX_W     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int DATA_W    = 32;
    localparam int DIV_W     = $clog2(DATA_W + 1);

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_DISPENSE = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DIV,
        ST_OUT,
        ST_EMPTY
    } state_t;

    // insert control broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic [DATA_W-1:0] val;
    } cell_ctl_t;

endpackage

// ----- sv/gcd_cell.sv -----
// one table slot: compares against the new word and takes either the new
// word or its upper neighbor's value, so the row stays sorted descending
module gcd_cell
    import gcd_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic              valid_in,
    input  logic              prev_valid,
    input  logic              prev_ge,
    input  logic [DATA_W-1:0] prev_val,
    output logic              ge,
    output logic [DATA_W-1:0] val
);

    logic [DATA_W-1:0] val_reg;

    // entry stays in front of the new word when it is valid and not smaller
    assign ge  = valid_in && (val_reg >= ctl.val);
    assign val = val_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.ins && !ge)
        begin
            if (prev_valid && !prev_ge)
                val_reg <= prev_val;
            else
                val_reg <= ctl.val;
        end
    end

endmodule

// ----- sv/gcd_div.sv -----
// restoring divider, one quotient bit per cycle
module gcd_div
    import gcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quot,
    output logic [DATA_W-1:0] rem
);

    logic [DATA_W-1:0] q_reg, r_reg, d_reg;
    logic [DIV_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   sub;

    assign trial = {r_reg, q_reg[DATA_W-1]};
    assign sub   = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // done follows the cycle of the final step, once quot and rem hold it
            done_reg <= busy_reg && (cnt_reg == DIV_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_W'(DATA_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_W'(1);
                if (cnt_reg == DIV_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!sub[DATA_W])
            begin
                r_reg <= sub[DATA_W-1:0];
                q_reg <= {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[DATA_W-1:0];
                q_reg <= {q_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ----- sv/greedy_change_dispenser.sv -----
// load, clear and unused mode complete without leaving idle
// dispense: per table entry a setup state that waits for a free output
//   slot, the divide unless the remainder is zero, then an output state
// empty table dispense: one status word
// one word in flight at a time; the serial divider sets throughput
// reset clears the entry count; table contents stay undefined until loaded
module greedy_change_dispenser
    import gcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [DATA_W-1:0] denomination,
    input  logic [DATA_W-1:0] amount,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] unit_value,
    output logic [DATA_W-1:0] unit_count,
    output logic [DATA_W-1:0] remainder,
    output logic              status,
    output logic              last
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  entries_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] ov_reg, oc_reg, or_reg;
    logic              ost_reg, olast_reg, ovalid_reg;
    cell_ctl_t         ctl;
    logic [DATA_W-1:0] cval [MAX_UNITS];
    logic              cge  [MAX_UNITS];
    logic              cvld [MAX_UNITS];
    logic              div_start, div_done;
    logic [DATA_W-1:0] div_q, div_r, cur_val;
    logic              is_last, take;

    assign take     = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign ctl.ins  = take && (mode == MODE_LOAD) && (denomination != '0)
                      && (entries_reg < CNT_W'(MAX_UNITS));
    assign ctl.val  = denomination;

    genvar g;
    generate
        for (g = 0; g < MAX_UNITS; g++)
        begin : g_cell
            assign cvld[g] = (entries_reg > CNT_W'(g));
            if (g == 0)
            begin : g_first
                gcd_cell u_cell (
                    .clk(clk), .ctl(ctl), .valid_in(cvld[g]),
                    .prev_valid(1'b0), .prev_ge(1'b1), .prev_val('0),
                    .ge(cge[g]), .val(cval[g])
                );
            end
            else
            begin : g_rest
                gcd_cell u_cell (
                    .clk(clk), .ctl(ctl), .valid_in(cvld[g]),
                    .prev_valid(cvld[g-1]), .prev_ge(cge[g-1]),
                    .prev_val(cval[g-1]), .ge(cge[g]), .val(cval[g])
                );
            end
        end
    endgenerate

    assign cur_val = cval[idx_reg];
    assign is_last = (CNT_W'(idx_reg) + CNT_W'(1)) == entries_reg;

    gcd_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(rem_reg), .divisor(cur_val),
        .done(div_done), .quot(div_q), .rem(div_r)
    );

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (take && mode == MODE_DISPENSE)
                    state_next = (entries_reg == '0) ? ST_EMPTY : ST_SHIFT;
            ST_SHIFT:
                if (!ovalid_reg || out_ready)
                begin
                    if (rem_reg != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_OUT;
                end
            ST_DIV:
                if (div_done)
                    state_next = ST_OUT;
            ST_OUT:
                state_next = is_last ? ST_IDLE : ST_SHIFT;
            ST_EMPTY:
                if (!ovalid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            entries_reg <= '0;
            ovalid_reg  <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT || (state_reg == ST_EMPTY && (!ovalid_reg || out_ready)))
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (ctl.ins)
                entries_reg <= entries_reg + CNT_W'(1);
            else if (take && mode == MODE_CLEAR)
                entries_reg <= '0;
            if (take)
                idx_reg <= '0;
            if (state_reg == ST_OUT)
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // st_out is entered only with the output slot free
    always_ff @(posedge clk)
    begin
        if (take)
            rem_reg <= amount;
        if (state_reg == ST_SHIFT && (!ovalid_reg || out_ready))
            oc_reg <= '0;
        if (div_done)
        begin
            oc_reg  <= div_q;
            rem_reg <= div_r;
        end
        if (state_reg == ST_OUT)
        begin
            ov_reg    <= cur_val;
            or_reg    <= rem_reg;
            ost_reg   <= 1'b0;
            olast_reg <= is_last;
        end
        if (state_reg == ST_EMPTY && (!ovalid_reg || out_ready))
        begin
            ov_reg    <= '0;
            oc_reg    <= '0;
            or_reg    <= rem_reg;
            ost_reg   <= 1'b1;
            olast_reg <= 1'b1;
        end
    end

    assign out_valid  = ovalid_reg;
    assign unit_value = ov_reg;
    assign unit_count = oc_reg;
    assign remainder  = or_reg;
    assign status     = ost_reg;
    assign last       = olast_reg;

    a_entries_max: assert property (@(posedge clk) disable iff (!rst_n)
        entries_reg <= CNT_W'(MAX_UNITS))
        else $error("entry count overflow");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> !ovalid_reg)
        else $error("output word overwritten");

endmodule
